@@ design/bbcm_pkg.sv @@
// shared constants and types for the block buffer cache manager
// no dependencies
package bbcm_pkg;
	localparam int SLOTS = 64;
	localparam int POOLS = 3;
	localparam int REF_BITS = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int POOL_W = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int ADDR_W = $clog2(SLOTS * POOLS);
	localparam int DEPTH = SLOTS * POOLS;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [REF_BITS-1:0] REF_MAX = '1;
	localparam logic [REF_BITS-1:0] REF_ONE = 1;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;
	localparam logic [1:0] OP_DIRTY = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_REF_FULL = 2'd2;
	localparam logic [1:0] ST_UNREF = 2'd3;

	// one slot entry as held in the slot memory
	typedef struct packed {
		logic [15:0] dev;
		logic [31:0] blk;
		logic [REF_BITS-1:0] refcnt;
		logic valid;
		logic dirty;
		logic idle;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [5:0] result_slot;
		logic hit;
		logic needs_fill;
		logic writeback;
		logic [15:0] wb_dev;
		logic [31:0] wb_block;
		logic [1:0] status;
	} result_t;
endpackage

@@ design/bbcm_ram.sv @@
// single port slot memory with registered read
// depends on bbcm_pkg
module bbcm_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [bbcm_pkg::ADDR_W-1:0] addr,
	input  bbcm_pkg::entry_t          wdata,
	output bbcm_pkg::entry_t          rdata
);
	bbcm_pkg::entry_t mem [bbcm_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ design/block_buffer_cache_manager_top.sv @@
// block buffer cache manager: sequencer, slot memory and per-pool counters
// depends on bbcm_pkg and bbcm_ram
//
// One item at a time. A get scans the pool's used slots for the (dev, block)
// pair, reading then comparing each slot, and when the pool is full a second
// pass over every slot picks the oldest idle slot, which is read again for a
// writeback of its old block when dirty and then granted. Release, fill done
// and set dirty read the named slot and update it in SLOT_OP. The next item
// is accepted only after the result has been taken. Speed is set by the
// single-port slot memory, read once per cycle.
// After reset a clearing pass over all SLOTS*POOLS entries (192) clears
// tags, reference counts and marks; no item is accepted during it.
module block_buffer_cache_manager_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[1:0], size_class[3:2], dev[19:4], block[51:20], slot[57:52], dirty_value[58]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_slot[5:0], hit[6], needs_fill[7], writeback[8], wb_dev[24:9],
	// wb_block[56:25], status[58:57]
	output logic [63:0] m_tdata
);
	typedef enum logic [3:0] {
		CLR, IDLE, RD_SLOT, WAIT_SLOT, SLOT_OP, SCAN_RD, SCAN_CHK,
		AGE_RD, AGE_CHK, AGE_RD2, AGE_WAIT, GRANT, OUT
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [bbcm_pkg::POOL_W-1:0] pool_q;
	logic [15:0] dev_q;
	logic [31:0] blk_q;
	logic [5:0] slot_in_q;
	logic dval_q;
	logic [bbcm_pkg::SLOT_W:0] idx_q;
	logic [bbcm_pkg::SLOT_W-1:0] best_q;
	logic [31:0] best_age_q;
	logic any_q;
	logic [bbcm_pkg::ADDR_W-1:0] clr_q;
	logic [bbcm_pkg::CNT_W-1:0] used_q [bbcm_pkg::POOLS];
	logic [31:0] stamp_q [bbcm_pkg::POOLS];
	bbcm_pkg::result_t res_q;

	logic we;
	logic [bbcm_pkg::ADDR_W-1:0] addr;
	bbcm_pkg::entry_t wdata, rdata;
	logic [bbcm_pkg::SLOT_W-1:0] cur_slot;
	logic [31:0] age;
	logic [1:0] in_op, in_sc;

	bbcm_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	assign in_op = s_tdata[1:0];
	assign in_sc = s_tdata[3:2];
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT);
	assign m_tdata = {5'd0, res_q.status, res_q.wb_block, res_q.wb_dev,
		res_q.writeback, res_q.needs_fill, res_q.hit, res_q.result_slot};
	assign age = stamp_q[pool_q] - rdata.stamp;

	// slot selection for the memory port
	always_comb begin
		unique case (state_q)
			RD_SLOT, WAIT_SLOT, SLOT_OP: cur_slot = slot_in_q[bbcm_pkg::SLOT_W-1:0];
			AGE_RD2, AGE_WAIT, GRANT: cur_slot = best_q;
			default: cur_slot = idx_q[bbcm_pkg::SLOT_W-1:0];
		endcase
	end

	always_comb begin
		addr = (state_q == CLR) ? clr_q :
			bbcm_pkg::ADDR_W'(pool_q * bbcm_pkg::SLOTS) + bbcm_pkg::ADDR_W'(cur_slot);
		we = 1'b0;
		wdata = rdata;
		if (state_q == CLR) begin
			we = 1'b1;
			wdata = '0;
		end else if (state_q == SLOT_OP) begin
			unique case (op_q)
				bbcm_pkg::OP_RELEASE: begin
					we = (rdata.refcnt != '0);
					if (rdata.dirty) begin
						wdata.dirty = 1'b0;
						wdata.valid = 1'b1;
					end
					wdata.refcnt = rdata.refcnt - 1'b1;
					if (rdata.refcnt == bbcm_pkg::REF_ONE) begin
						wdata.idle = 1'b1;
						wdata.stamp = stamp_q[pool_q];
					end
				end
				bbcm_pkg::OP_FILL: begin
					we = 1'b1;
					wdata.dirty = 1'b0;
					wdata.valid = 1'b1;
				end
				bbcm_pkg::OP_DIRTY: begin
					we = 1'b1;
					wdata.dirty = dval_q;
				end
				default: ;
			endcase
		end else if (state_q == SCAN_CHK && rdata.dev == dev_q && rdata.blk == blk_q
				&& rdata.refcnt != bbcm_pkg::REF_MAX) begin
			we = 1'b1;
			wdata.refcnt = rdata.refcnt + 1'b1;
			wdata.idle = 1'b0;
		end else if (state_q == GRANT) begin
			we = 1'b1;
			wdata = '0;
			wdata.dev = dev_q;
			wdata.blk = blk_q;
			wdata.refcnt = bbcm_pkg::REF_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			clr_q <= '0;
			for (int i = 0; i < bbcm_pkg::POOLS; i++) begin
				used_q[i] <= '0;
				stamp_q[i] <= '0;
			end
			res_q <= '0;
			idx_q <= '0;
			best_q <= '0;
			best_age_q <= '0;
			any_q <= 1'b0;
			op_q <= '0;
			pool_q <= '0;
			dev_q <= '0;
			blk_q <= '0;
			slot_in_q <= '0;
			dval_q <= 1'b0;
		end else begin
			unique case (state_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == bbcm_pkg::ADDR_W'(bbcm_pkg::DEPTH - 1)) state_q <= IDLE;
				end
				IDLE: if (s_tvalid) begin
					op_q <= in_op;
					pool_q <= bbcm_pkg::POOL_W'(in_sc);
					dev_q <= s_tdata[19:4];
					blk_q <= s_tdata[51:20];
					slot_in_q <= s_tdata[57:52];
					dval_q <= s_tdata[58];
					idx_q <= '0;
					any_q <= 1'b0;
					if (32'(in_sc) >= bbcm_pkg::POOLS) begin
						res_q <= '{status: bbcm_pkg::ST_NO_SLOT, default: '0};
						state_q <= OUT;
					end else if (in_op == bbcm_pkg::OP_GET) begin
						res_q <= '0;
						state_q <= SCAN_RD;
					end else if (32'(s_tdata[57:52]) >= bbcm_pkg::SLOTS) begin
						res_q <= '{result_slot: s_tdata[57:52],
							status: bbcm_pkg::ST_NO_SLOT, default: '0};
						state_q <= OUT;
					end else begin
						res_q <= '0;
						state_q <= RD_SLOT;
					end
				end
				RD_SLOT: state_q <= WAIT_SLOT;
				WAIT_SLOT: state_q <= SLOT_OP;
				SLOT_OP: begin
					res_q.result_slot <= slot_in_q;
					if (op_q == bbcm_pkg::OP_RELEASE) begin
						if (rdata.refcnt == '0) begin
							res_q.status <= bbcm_pkg::ST_UNREF;
						end else begin
							if (rdata.dirty) begin
								res_q.writeback <= 1'b1;
								res_q.wb_dev <= rdata.dev;
								res_q.wb_block <= rdata.blk;
							end
							if (rdata.refcnt == bbcm_pkg::REF_ONE)
								stamp_q[pool_q] <= stamp_q[pool_q] + 1'b1;
						end
					end
					state_q <= OUT;
				end
				SCAN_RD: begin
					if (idx_q == (bbcm_pkg::SLOT_W+1)'(used_q[pool_q])) begin
						if (32'(used_q[pool_q]) < bbcm_pkg::SLOTS) begin
							best_q <= idx_q[bbcm_pkg::SLOT_W-1:0];
							used_q[pool_q] <= used_q[pool_q] + 1'b1;
							state_q <= GRANT;
						end else begin
							idx_q <= '0;
							state_q <= AGE_RD;
						end
					end else begin
						state_q <= SCAN_CHK;
					end
				end
				SCAN_CHK: begin
					if (rdata.dev == dev_q && rdata.blk == blk_q) begin
						res_q.result_slot <= 6'(idx_q[bbcm_pkg::SLOT_W-1:0]);
						res_q.hit <= 1'b1;
						res_q.needs_fill <= !rdata.valid;
						res_q.status <= (rdata.refcnt == bbcm_pkg::REF_MAX) ?
							bbcm_pkg::ST_REF_FULL : bbcm_pkg::ST_OK;
						state_q <= OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= SCAN_RD;
					end
				end
				AGE_RD: begin
					if (idx_q == (bbcm_pkg::SLOT_W+1)'(bbcm_pkg::SLOTS)) begin
						if (any_q) begin
							state_q <= AGE_RD2;
						end else begin
							res_q.status <= bbcm_pkg::ST_NO_SLOT;
							state_q <= OUT;
						end
					end else begin
						state_q <= AGE_CHK;
					end
				end
				AGE_CHK: begin
					if (rdata.idle && (!any_q || age > best_age_q)) begin
						any_q <= 1'b1;
						best_age_q <= age;
						best_q <= idx_q[bbcm_pkg::SLOT_W-1:0];
					end
					idx_q <= idx_q + 1'b1;
					state_q <= AGE_RD;
				end
				AGE_RD2: state_q <= AGE_WAIT;
				AGE_WAIT: begin
					if (rdata.dirty) begin
						res_q.writeback <= 1'b1;
						res_q.wb_dev <= rdata.dev;
						res_q.wb_block <= rdata.blk;
					end
					state_q <= GRANT;
				end
				GRANT: begin
					res_q.result_slot <= 6'(best_q);
					res_q.needs_fill <= 1'b1;
					state_q <= OUT;
				end
				OUT: if (m_tready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	// a release never reports writeback when refused
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.status == bbcm_pkg::ST_UNREF |-> !res_q.writeback)
		else $error("writeback with unreferenced release");
	// a hit never asks for a writeback
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.hit |-> !res_q.writeback)
		else $error("hit with writeback");
	// result holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
endmodule

@@ tb/sv/block_buffer_cache_manager_top_tb.sv @@
// testbench for the block buffer cache manager: random and directed cache operations
// depends on bbcm_pkg and the block_buffer_cache_manager_top design
module block_buffer_cache_manager_top_tb;
	typedef struct {
		logic [1:0]  op;
		logic [1:0]  pool;
		logic [15:0] dev;
		logic [31:0] blk;
		logic [5:0]  slot;
		logic        dval;
	} req_t;

	typedef struct packed {
		logic [5:0]  rslot;
		logic        hit;
		logic        fill;
		logic        wb;
		logic [15:0] wdev;
		logic [31:0] wblk;
		logic [1:0]  status;
	} answer_t;

	class cache_scoreboard;
		logic [15:0] s_dev [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		logic [31:0] s_blk [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		int unsigned s_ref [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		bit s_valid [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		bit s_dirty [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		bit s_idle [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		logic [31:0] s_stamp [bbcm_pkg::POOLS][bbcm_pkg::SLOTS];
		int unsigned used [bbcm_pkg::POOLS];
		logic [31:0] stamp_ctr [bbcm_pkg::POOLS];
		answer_t pending[$];
		int errors;
		int answers_seen;
		int hits;
		int writebacks;

		function new();
			for (int p = 0; p < bbcm_pkg::POOLS; p++) begin
				used[p] = 0;
				stamp_ctr[p] = 0;
				for (int s = 0; s < bbcm_pkg::SLOTS; s++) begin
					s_ref[p][s] = 0;
					s_valid[p][s] = 0;
					s_dirty[p][s] = 0;
					s_idle[p][s] = 0;
					s_dev[p][s] = 0;
					s_blk[p][s] = 0;
					s_stamp[p][s] = 0;
				end
			end
			errors = 0;
			answers_seen = 0;
			hits = 0;
			writebacks = 0;
		endfunction

		function answer_t lookup(int p, logic [15:0] dev, logic [31:0] blk);
			answer_t a;
			int s;
			int found;
			logic [31:0] age;
			logic [31:0] best;
			a = '0;
			found = -1;
			for (int i = 0; i < used[p]; i++)
				if (found < 0 && s_dev[p][i] == dev && s_blk[p][i] == blk)
					found = i;
			if (found >= 0) begin
				a.rslot = 6'(found);
				a.hit = 1;
				a.fill = !s_valid[p][found];
				if (s_ref[p][found] >= 2 ** bbcm_pkg::REF_BITS - 1) begin
					a.status = bbcm_pkg::ST_REF_FULL;
					return a;
				end
				s_ref[p][found]++;
				s_idle[p][found] = 0;
				return a;
			end
			s = -1;
			if (used[p] < bbcm_pkg::SLOTS) begin
				s = used[p];
				used[p]++;
			end else begin
				best = 0;
				for (int i = 0; i < bbcm_pkg::SLOTS; i++)
					if (s_idle[p][i]) begin
						age = stamp_ctr[p] - s_stamp[p][i];
						if (s < 0 || age > best) begin
							s = i;
							best = age;
						end
					end
				if (s < 0) begin
					a.status = bbcm_pkg::ST_NO_SLOT;
					return a;
				end
				if (s_dirty[p][s]) begin
					a.wb = 1;
					a.wdev = s_dev[p][s];
					a.wblk = s_blk[p][s];
				end
			end
			s_dev[p][s] = dev;
			s_blk[p][s] = blk;
			s_ref[p][s] = 1;
			s_valid[p][s] = 0;
			s_dirty[p][s] = 0;
			s_idle[p][s] = 0;
			a.rslot = 6'(s);
			a.fill = 1;
			return a;
		endfunction

		function void note_request(req_t r);
			answer_t a;
			int p;
			int s;
			a = '0;
			p = int'(r.pool);
			s = int'(r.slot);
			if (p >= bbcm_pkg::POOLS) begin
				a.status = bbcm_pkg::ST_NO_SLOT;
			end else if (r.op == bbcm_pkg::OP_GET) begin
				a = lookup(p, r.dev, r.blk);
			end else if (s >= bbcm_pkg::SLOTS) begin
				a.rslot = r.slot;
				a.status = bbcm_pkg::ST_NO_SLOT;
			end else begin
				a.rslot = r.slot;
				case (r.op)
					bbcm_pkg::OP_RELEASE: begin
						if (s_ref[p][s] == 0) begin
							a.status = bbcm_pkg::ST_UNREF;
						end else begin
							if (s_dirty[p][s]) begin
								a.wb = 1;
								a.wdev = s_dev[p][s];
								a.wblk = s_blk[p][s];
								s_dirty[p][s] = 0;
								s_valid[p][s] = 1;
							end
							s_ref[p][s]--;
							if (s_ref[p][s] == 0) begin
								s_idle[p][s] = 1;
								s_stamp[p][s] = stamp_ctr[p];
								stamp_ctr[p] = stamp_ctr[p] + 1;
							end
						end
					end
					bbcm_pkg::OP_FILL: begin
						s_valid[p][s] = 1;
						s_dirty[p][s] = 0;
					end
					default: s_dirty[p][s] = r.dval;
				endcase
			end
			pending.push_back(a);
		endfunction

		function void check_answer(logic [63:0] d);
			answer_t e;
			answer_t g;
			g.rslot = d[5:0];
			g.hit = d[6];
			g.fill = d[7];
			g.wb = d[8];
			g.wdev = d[24:9];
			g.wblk = d[56:25];
			g.status = d[58:57];
			answers_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (g.hit) hits++;
			if (g.wb) writebacks++;
			if (g.rslot != e.rslot)
				$display("%0t: slot exp %0d got %0d", $time, e.rslot, g.rslot);
			if (g.hit != e.hit)
				$display("%0t: hit exp %0d got %0d", $time, e.hit, g.hit);
			if (g.fill != e.fill)
				$display("%0t: needs_fill exp %0d got %0d", $time, e.fill, g.fill);
			if (g.wb != e.wb)
				$display("%0t: writeback exp %0d got %0d", $time, e.wb, g.wb);
			if (g.wdev != e.wdev)
				$display("%0t: wb_dev exp %h got %h", $time, e.wdev, g.wdev);
			if (g.wblk != e.wblk)
				$display("%0t: wb_block exp %h got %h", $time, e.wblk, g.wblk);
			if (g.status != e.status)
				$display("%0t: status exp %0d got %0d", $time, e.status, g.status);
			if (g != e) errors++;
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;

	cache_scoreboard board;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	logic [15:0] recent_dev [8];
	logic [31:0] recent_blk [8];

	block_buffer_cache_manager_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// sink side: random stall at the falling edge, check at the rising edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_answer(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("block_buffer_cache_manager_top_tb: done, errors");
				$finish;
			end
		end
	end

	// valid stays high from one item to the next unless the sender idles
	task automatic send(req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tdata <= {5'd0, r.dval, r.slot, r.blk, r.dev, r.pool, r.op};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_op(logic [1:0] op, logic [1:0] pool, logic [15:0] dev,
			logic [31:0] blk, logic [5:0] slot, logic dval);
		req_t r;
		r.op = op; r.pool = pool; r.dev = dev; r.blk = blk; r.slot = slot; r.dval = dval;
		send(r);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// mostly well-formed traffic over a small working set so hits, releases,
	// evictions and dirty writebacks all happen often
	task automatic random_phase(int n);
		req_t r;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(7);
			r.op = 2'($urandom_range(3));
			r.pool = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
			r.dev = recent_dev[k];
			r.blk = recent_blk[k];
			r.slot = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) :
				6'($urandom_range(15));
			r.dval = 1'($urandom_range(1));
			if ($urandom_range(15) == 0) begin
				recent_dev[k] = 16'($urandom);
				recent_blk[k] = $urandom;
			end
			if ($urandom_range(5) == 0) begin
				r.dev = 16'($urandom);
				r.blk = $urandom;
			end
			send(r);
		end
	endtask

	initial begin
		board = new();
		for (int i = 0; i < 8; i++) begin
			recent_dev[i] = 16'($urandom);
			recent_blk[i] = $urandom;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every operation, invalid pool, unreferenced release
		send_op(bbcm_pkg::OP_GET, 2'd0, 16'hffff, 32'hffffffff, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_GET, 2'd0, 16'h0000, 32'h00000000, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_GET, 2'd0, 16'hffff, 32'hffffffff, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_FILL, 2'd0, 16'd0, 32'd0, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_DIRTY, 2'd0, 16'd0, 32'd0, 6'd0, 1'b1);
		send_op(bbcm_pkg::OP_RELEASE, 2'd0, 16'd0, 32'd0, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_RELEASE, 2'd0, 16'd0, 32'd0, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_RELEASE, 2'd0, 16'd0, 32'd0, 6'd0, 1'b0);
		send_op(bbcm_pkg::OP_DIRTY, 2'd0, 16'd0, 32'd0, 6'd1, 1'b0);
		send_op(bbcm_pkg::OP_GET, 2'd3, 16'h1234, 32'h5678, 6'd63, 1'b1);
		send_op(bbcm_pkg::OP_RELEASE, 2'd2, 16'd0, 32'd0, 6'd63, 1'b0);
		send_op(bbcm_pkg::OP_DIRTY, 2'd1, 16'd0, 32'd0, 6'd63, 1'b1);
		send_op(bbcm_pkg::OP_FILL, 2'd2, 16'd0, 32'd0, 6'd42, 1'b0);
		drain();

		// count full: repeated gets of one block in pool 1
		for (int i = 0; i < 257; i++)
			send_op(bbcm_pkg::OP_GET, 2'd1, 16'haaaa, 32'h55555555, 6'd0, 1'b0);
		drain();
		// fill pool 2, hit no slot free, then free and dirty some idle slots
		for (int i = 0; i < 65; i++)
			send_op(bbcm_pkg::OP_GET, 2'd2, i[15:0], 32'h1000 + i, 6'd0, 1'b0);
		for (int i = 0; i < 6; i++) begin
			send_op(bbcm_pkg::OP_DIRTY, 2'd2, 16'd0, 32'd0, i[5:0], 1'b1);
			send_op(bbcm_pkg::OP_RELEASE, 2'd2, 16'd0, 32'd0, i[5:0], 1'b0);
			send_op(bbcm_pkg::OP_DIRTY, 2'd2, 16'd0, 32'd0, i[5:0], i[0]);
		end
		for (int i = 0; i < 8; i++)
			send_op(bbcm_pkg::OP_GET, 2'd2, 16'hbeef, 32'h9000 + i, 6'd0, 1'b0);
		drain();

		src_idle_pct = 0; sink_stall_pct = 0;
		random_phase(250);
		src_idle_pct = 80; sink_stall_pct = 0;
		random_phase(250);
		src_idle_pct = 0; sink_stall_pct = 80;
		random_phase(250);
		src_idle_pct = 27; sink_stall_pct = 27;
		random_phase(250);
		src_idle_pct = 0; sink_stall_pct = 0;
		random_phase(140);
		drain();

		$display("covered %0d items, %0d results, %0d hits, %0d writebacks",
			items_sent, board.answers_seen, board.hits, board.writebacks);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("block_buffer_cache_manager_top_tb: done, clean");
		else
			$display("block_buffer_cache_manager_top_tb: done, errors");
		$finish;
	end
endmodule

@@ filelist.f @@
design/bbcm_pkg.sv
design/bbcm_ram.sv
design/block_buffer_cache_manager_top.sv
tb/sv/block_buffer_cache_manager_top_tb.sv
